[rtl/core/capr_pkg.sv]
// Shared types, constants and helper functions for the complex ALU with
// polar-to-rectangular conversion. No dependencies.
package capr_pkg;

  // Angle and CORDIC datapath widths (angles carry 30 fractional bits).
  localparam int Z_W       = 34;
  localparam int X_W       = 33;
  localparam int ATAN_N    = 24;

  // The divider produces 33 quotient bits, one per stage.
  localparam int DIV_STEPS = 33;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam logic signed [Z_W-1:0] K30       = 34'sd652032874;
  localparam logic signed [Z_W-1:0] PI30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI30 = 34'sd1686629713;

  // atan(2^-i) with 30 fractional bits.
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               sat;
  } rect_t;

  // Clip a wide signed value to the 32-bit range and report clipping.
  function automatic sat_t sat_q32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sd2147483647) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < -66'sd2147483648) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = 32'(v);
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/core/complex_alu_polar_rect_top.sv]
// Register stages from input transaction to result: CORDIC_STAGES + 5
// conversion, 3 arithmetic, 35 divider, 1 output stage. Throughput: one
// transaction per cycle while the skid register is empty; every stage is a
// register stage. The 33-stage divider pipeline and the unrolled CORDIC
// set the depth. Reset (rst_ni low, asynchronous) clears the stage valid
// bits and the output skid register; the datapath registers are not reset.
module complex_alu_polar_rect_top #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic               a_is_polar_i,
  input  logic signed [31:0] a_first_i,
  input  logic signed [31:0] a_second_i,
  input  logic               b_is_polar_i,
  input  logic signed [31:0] b_first_i,
  input  logic signed [31:0] b_second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_real_o,
  output logic signed [31:0] res_imag_o,
  output logic               div_zero_o,
  output logic               saturated_o
);

  // The whole pipeline advances together. Stalls are absorbed by a one-entry
  // skid register behind the output stage: when a result is not taken, it
  // moves into the skid register while the pipeline still advances once,
  // and only then does the pipeline freeze. in_ready_o is thus a register.
  localparam int RECT_LAT  = CORDIC_STAGES + 5;
  localparam int DIV_LAT   = capr_pkg::DIV_LAT;
  localparam int TOTAL_LAT = RECT_LAT + 3 + DIV_LAT + 1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               fa;
    logic               fb;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic signed [63:0] p_arbr;
    logic signed [63:0] p_aibi;
    logic signed [63:0] p_arbi;
    logic signed [63:0] p_aibr;
    logic signed [63:0] p_brbr;
    logic signed [63:0] p_bibi;
  } t1_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               fab;
    logic signed [32:0] as_re;
    logic signed [32:0] as_im;
    logic signed [63:0] q_arbr;
    logic signed [63:0] q_aibi;
    logic signed [63:0] q_arbi;
    logic signed [63:0] q_aibr;
    logic signed [64:0] s1;
    logic signed [64:0] s2;
    logic [63:0]        den;
  } t2_t;

  typedef struct packed {
    logic signed [65:0] pre_re;
    logic signed [65:0] pre_im;
    logic               fab;
    logic               is_div;
    logic               dz;
    logic [63:0]        mag1;
    logic               neg1;
    logic [63:0]        mag2;
    logic               neg2;
    logic [63:0]        den;
  } t3_t;

  // Results of the non-divide commands, carried alongside the divider.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               sat;
    logic               is_div;
    logic               dz;
  } side_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
    logic               sat;
  } out_t;

  logic                   en;
  logic [TOTAL_LAT-1:0]   vld_q;
  logic [2:0]             cmd_dly_q [RECT_LAT];
  capr_pkg::rect_t        rect_a, rect_b;
  t1_t                    t1_d, t1_q;
  t2_t                    t2_d, t2_q;
  t3_t                    t3_d, t3_q;
  side_t                  side_d;
  side_t                  side_dly_q [DIV_LAT];
  capr_pkg::sat_t         div_re, div_im;
  out_t                   out_d, out_q, skid_q;
  logic                   skid_v_q, skid_v_d;
  logic                   out_v;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign out_v      = vld_q[TOTAL_LAT-1];

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  // Operand conversion; rectangular operands pass through unchanged.
  capr_rect #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rect_a (
    .clk_i      (clk_i),
    .en_i       (en),
    .is_polar_i (a_is_polar_i),
    .first_i    (a_first_i),
    .second_i   (a_second_i),
    .rect_o     (rect_a)
  );

  capr_rect #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_rect_b (
    .clk_i      (clk_i),
    .en_i       (en),
    .is_polar_i (b_is_polar_i),
    .first_i    (b_first_i),
    .second_i   (b_second_i),
    .rect_o     (rect_b)
  );

  // The command waits beside the conversion pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_dly_q[0] <= cmd_i;
      for (int k = 1; k < RECT_LAT; k++) begin
        cmd_dly_q[k] <= cmd_dly_q[k-1];
      end
    end
  end

  // Stage T1: all six partial products, each a 32 by 32 signed multiply.
  always_comb begin
    t1_d.cmd    = cmd_dly_q[RECT_LAT-1];
    t1_d.fa     = rect_a.sat;
    t1_d.fb     = rect_b.sat;
    t1_d.ar     = rect_a.re;
    t1_d.ai     = rect_a.im;
    t1_d.br     = rect_b.re;
    t1_d.bi     = rect_b.im;
    t1_d.p_arbr = rect_a.re * rect_b.re;
    t1_d.p_aibi = rect_a.im * rect_b.im;
    t1_d.p_arbi = rect_a.re * rect_b.im;
    t1_d.p_aibr = rect_a.im * rect_b.re;
    t1_d.p_brbr = rect_b.re * rect_b.re;
    t1_d.p_bibi = rect_b.im * rect_b.im;
  end

  // Stage T2: sums for add, subtract and negate, rounded products for
  // multiply, and the divide numerators and divisor.
  always_comb begin
    logic signed [64:0] rnd;
    logic signed [64:0] tmp;
    rnd        = 65'sd1 <<< (FRAC_BITS - 1);
    t2_d.cmd   = t1_q.cmd;
    t2_d.as_re = '0;
    t2_d.as_im = '0;
    t2_d.fab   = 1'b0;
    case (t1_q.cmd)
      capr_pkg::CMD_ADD: begin
        t2_d.as_re = 33'(t1_q.ar) + 33'(t1_q.br);
        t2_d.as_im = 33'(t1_q.ai) + 33'(t1_q.bi);
        t2_d.fab   = t1_q.fa | t1_q.fb;
      end
      capr_pkg::CMD_SUB: begin
        t2_d.as_re = 33'(t1_q.ar) - 33'(t1_q.br);
        t2_d.as_im = 33'(t1_q.ai) - 33'(t1_q.bi);
        t2_d.fab   = t1_q.fa | t1_q.fb;
      end
      capr_pkg::CMD_MUL: begin
        t2_d.fab = t1_q.fa | t1_q.fb;
      end
      capr_pkg::CMD_DIV: begin
        t2_d.fab = t1_q.fa | t1_q.fb;
      end
      capr_pkg::CMD_NEG: begin
        t2_d.as_re = -33'(t1_q.ar);
        t2_d.as_im = -33'(t1_q.ai);
        t2_d.fab   = t1_q.fa;
      end
      default: begin
        t2_d.fab = 1'b0;
      end
    endcase
    tmp         = 65'(t1_q.p_arbr) + rnd;
    t2_d.q_arbr = 64'(tmp >>> FRAC_BITS);
    tmp         = 65'(t1_q.p_aibi) + rnd;
    t2_d.q_aibi = 64'(tmp >>> FRAC_BITS);
    tmp         = 65'(t1_q.p_arbi) + rnd;
    t2_d.q_arbi = 64'(tmp >>> FRAC_BITS);
    tmp         = 65'(t1_q.p_aibr) + rnd;
    t2_d.q_aibr = 64'(tmp >>> FRAC_BITS);
    t2_d.s1     = 65'(t1_q.p_arbr) + 65'(t1_q.p_aibi);
    t2_d.s2     = 65'(t1_q.p_aibr) - 65'(t1_q.p_arbi);
    t2_d.den    = 64'(t1_q.p_brbr) + 64'(t1_q.p_bibi);
  end

  // Stage T3: multiply results, numerator magnitudes and signs, zero check.
  always_comb begin
    t3_d.fab    = t2_q.fab;
    t3_d.is_div = (t2_q.cmd == capr_pkg::CMD_DIV);
    t3_d.dz     = t3_d.is_div && (t2_q.den == 64'd0);
    t3_d.den    = t2_q.den;
    if (t2_q.cmd == capr_pkg::CMD_MUL) begin
      t3_d.pre_re = 66'(t2_q.q_arbr) - 66'(t2_q.q_aibi);
      t3_d.pre_im = 66'(t2_q.q_arbi) + 66'(t2_q.q_aibr);
    end else begin
      t3_d.pre_re = 66'(t2_q.as_re);
      t3_d.pre_im = 66'(t2_q.as_im);
    end
    t3_d.neg1 = t2_q.s1[64];
    t3_d.mag1 = t2_q.s1[64] ? 64'(-t2_q.s1) : 64'(t2_q.s1);
    t3_d.neg2 = t2_q.s2[64];
    t3_d.mag2 = t2_q.s2[64] ? 64'(-t2_q.s2) : 64'(t2_q.s2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
      t3_q <= t3_d;
    end
  end

  capr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (t3_q.mag1),
    .neg_i (t3_q.neg1),
    .den_i (t3_q.den),
    .res_o (div_re)
  );

  capr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (t3_q.mag2),
    .neg_i (t3_q.neg2),
    .den_i (t3_q.den),
    .res_o (div_im)
  );

  // Non-divide results are saturated here and wait beside the divider.
  always_comb begin
    capr_pkg::sat_t sre;
    capr_pkg::sat_t sim;
    sre           = capr_pkg::sat_q32(t3_q.pre_re);
    sim           = capr_pkg::sat_q32(t3_q.pre_im);
    side_d.re     = sre.val;
    side_d.im     = sim.val;
    side_d.sat    = t3_q.fab | sre.clip | sim.clip;
    side_d.is_div = t3_q.is_div;
    side_d.dz     = t3_q.dz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dly_q[0] <= side_d;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_dly_q[k] <= side_dly_q[k-1];
      end
    end
  end

  // Output stage: a zero divisor forces zero parts and clears the saturation flag.
  always_comb begin
    side_t s;
    s = side_dly_q[DIV_LAT-1];
    if (s.dz) begin
      out_d.re  = '0;
      out_d.im  = '0;
      out_d.dz  = 1'b1;
      out_d.sat = 1'b0;
    end else if (s.is_div) begin
      out_d.re  = div_re.val;
      out_d.im  = div_im.val;
      out_d.dz  = 1'b0;
      out_d.sat = s.sat | div_re.clip | div_im.clip;
    end else begin
      out_d.re  = s.re;
      out_d.im  = s.im;
      out_d.dz  = 1'b0;
      out_d.sat = s.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Skid register: catches the output-stage transaction when it is not
  // taken, so the pipeline can advance one more time before it freezes.
  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_d = 1'b0;
      end
    end else if (out_v && !out_ready_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && out_v && !out_ready_i) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_v_q | out_v;
  assign res_real_o  = skid_v_q ? skid_q.re  : out_q.re;
  assign res_imag_o  = skid_v_q ? skid_q.im  : out_q.im;
  assign div_zero_o  = skid_v_q ? skid_q.dz  : out_q.dz;
  assign saturated_o = skid_v_q ? skid_q.sat : out_q.sat;

`ifndef ASSERT_OFF
  // While the skid register is occupied the pipeline must not move.
  a_freeze_on_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(vld_q))
    else $error("pipeline advanced while skid register was full");

  // A zero divisor always yields zero parts and no saturation flag.
  a_div_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |->
      res_real_o == 32'sd0 && res_imag_o == 32'sd0 && !saturated_o)
    else $error("divide-by-zero result not cleared");

  // Draining the skid register exposes the waiting output-stage transaction.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_ready_i && out_v |=> out_valid_o && !skid_v_q)
    else $error("transaction behind skid register lost");
`endif

endmodule

[rtl/core/capr_rect.sv]
// Pipelined polar-to-rectangular converter: angle clamp, quadrant fold,
// unrolled CORDIC stages, magnitude multiply and rounding. Uses capr_pkg.
module capr_rect #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                is_polar_i,
  input  logic signed [31:0]  first_i,
  input  logic signed [31:0]  second_i,
  output capr_pkg::rect_t     rect_o
);

  localparam int SH   = 30 - FRAC_BITS;
  localparam int ZW   = 32 + SH;
  localparam int LAST = CORDIC_STAGES + 2;

  typedef struct packed {
    logic                           polar;
    logic signed [31:0]             f;
    logic signed [31:0]             g;
    logic signed [capr_pkg::Z_W-1:0] z;
    logic                           flip;
    logic signed [capr_pkg::X_W-1:0] x;
    logic signed [capr_pkg::X_W-1:0] y;
  } stg_t;

  typedef struct packed {
    logic               polar;
    logic               flip;
    logic signed [31:0] f;
    logic signed [31:0] g;
    logic signed [64:0] pre;
    logic signed [64:0] pim;
  } mul_t;

  stg_t            stg_q [LAST+1];
  stg_t            in_d, clamp_d, fold_d;
  mul_t            mul_d, mul_q;
  capr_pkg::rect_t out_d, out_q;

  always_comb begin
    in_d       = '0;
    in_d.polar = is_polar_i;
    in_d.f     = first_i;
    in_d.g     = second_i;
  end

  // Scale the angle to 30 fractional bits and clamp it to +-pi.
  always_comb begin
    logic signed [ZW-1:0] zext;
    zext    = ZW'(stg_q[0].g) <<< SH;
    clamp_d = stg_q[0];
    if (zext > ZW'(capr_pkg::PI30)) begin
      clamp_d.z = capr_pkg::PI30;
    end else if (zext < -ZW'(capr_pkg::PI30)) begin
      clamp_d.z = -capr_pkg::PI30;
    end else begin
      clamp_d.z = capr_pkg::Z_W'(zext);
    end
  end

  // Fold the outer half-planes onto the inner one; the result is negated later.
  always_comb begin
    logic signed [capr_pkg::Z_W-1:0] zc;
    zc     = stg_q[1].z;
    fold_d = stg_q[1];
    fold_d.flip = 1'b0;
    if (zc > capr_pkg::HALF_PI30) begin
      fold_d.z    = zc - capr_pkg::PI30;
      fold_d.flip = 1'b1;
    end else if (zc < -capr_pkg::HALF_PI30) begin
      fold_d.z    = zc + capr_pkg::PI30;
      fold_d.flip = 1'b1;
    end
    fold_d.x = capr_pkg::X_W'(capr_pkg::K30);
    fold_d.y = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= in_d;
      stg_q[1] <= clamp_d;
      stg_q[2] <= fold_d;
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_iter
    stg_t it_d;

    always_comb begin
      logic signed [capr_pkg::X_W-1:0] xs;
      logic signed [capr_pkg::X_W-1:0] ys;
      logic signed [capr_pkg::Z_W-1:0] zs;
      logic signed [capr_pkg::Z_W-1:0] at;
      xs   = stg_q[j+2].x;
      ys   = stg_q[j+2].y;
      zs   = stg_q[j+2].z;
      at   = $signed({2'b00, capr_pkg::ATAN_TAB[j]});
      it_d = stg_q[j+2];
      if (!zs[capr_pkg::Z_W-1]) begin
        it_d.x = xs - (ys >>> j);
        it_d.y = ys + (xs >>> j);
        it_d.z = zs - at;
      end else begin
        it_d.x = xs + (ys >>> j);
        it_d.y = ys - (xs >>> j);
        it_d.z = zs + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j+3] <= it_d;
      end
    end
  end

  always_comb begin
    logic signed [31:0]              fs;
    logic signed [capr_pkg::X_W-1:0] xs;
    logic signed [capr_pkg::X_W-1:0] ys;
    fs          = stg_q[LAST].f;
    xs          = stg_q[LAST].x;
    ys          = stg_q[LAST].y;
    mul_d.polar = stg_q[LAST].polar;
    mul_d.flip  = stg_q[LAST].flip;
    mul_d.f     = stg_q[LAST].f;
    mul_d.g     = stg_q[LAST].g;
    mul_d.pre   = fs * xs;
    mul_d.pim   = fs * ys;
  end

  // A folded angle negates the product: ~P + 1 + round equals -P + round.
  always_comb begin
    logic signed [64:0] tre;
    logic signed [64:0] tim;
    capr_pkg::sat_t     sre;
    capr_pkg::sat_t     sim;
    if (mul_q.flip) begin
      tre = ~mul_q.pre + 65'sd536870913;
      tim = ~mul_q.pim + 65'sd536870913;
    end else begin
      tre = mul_q.pre + 65'sd536870912;
      tim = mul_q.pim + 65'sd536870912;
    end
    sre = capr_pkg::sat_q32(66'(tre >>> 30));
    sim = capr_pkg::sat_q32(66'(tim >>> 30));
    if (mul_q.polar) begin
      out_d.re  = sre.val;
      out_d.im  = sim.val;
      out_d.sat = sre.clip | sim.clip;
    end else begin
      out_d.re  = mul_q.f;
      out_d.im  = mul_q.g;
      out_d.sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
      out_q <= out_d;
    end
  end

  assign rect_o = out_q;

endmodule

[rtl/core/capr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sign
// application and 32-bit saturation. Uses capr_pkg.
module capr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [63:0]    mag_i,
  input  logic           neg_i,
  input  logic [63:0]    den_i,
  output capr_pkg::sat_t res_o
);

  localparam int STEPS = capr_pkg::DIV_STEPS;

  typedef struct packed {
    logic [63:0]      rem;
    logic [STEPS-1:0] quo;
    logic [63:0]      mag;
    logic [63:0]      den;
    logic             neg;
    logic             ovf;
  } dstg_t;

  dstg_t          stg_q [STEPS+1];
  dstg_t          init_d;
  capr_pkg::sat_t res_d, res_q;

  // The quotient overflows 33 bits exactly when the top part already
  // reaches the divisor; the saturated result then does not need it.
  always_comb begin
    logic [63:0] r0;
    r0         = mag_i >> (STEPS - FRAC_BITS);
    init_d.rem = r0;
    init_d.quo = '0;
    init_d.mag = mag_i;
    init_d.den = den_i;
    init_d.neg = neg_i;
    init_d.ovf = (r0 >= den_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= init_d;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    logic  nbit;
    dstg_t st_d;

    if (K >= FRAC_BITS) begin : g_bit
      assign nbit = stg_q[j].mag[K-FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      logic [64:0] rs;
      rs   = {stg_q[j].rem, nbit};
      st_d = stg_q[j];
      if (rs >= {1'b0, stg_q[j].den}) begin
        st_d.rem = 64'(rs - {1'b0, stg_q[j].den});
        st_d.quo = {stg_q[j].quo[STEPS-2:0], 1'b1};
      end else begin
        st_d.rem = rs[63:0];
        st_d.quo = {stg_q[j].quo[STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j+1] <= st_d;
      end
    end
  end

  always_comb begin
    logic [STEPS-1:0] q;
    q = stg_q[STEPS].quo;
    if (stg_q[STEPS].ovf) begin
      res_d.val  = stg_q[STEPS].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res_d.clip = 1'b1;
    end else if (stg_q[STEPS].neg) begin
      if (q > 33'd2147483648) begin
        res_d.val  = 32'sh8000_0000;
        res_d.clip = 1'b1;
      end else begin
        res_d.val  = 32'(-q);
        res_d.clip = 1'b0;
      end
    end else begin
      if (q > 33'd2147483647) begin
        res_d.val  = 32'sh7FFF_FFFF;
        res_d.clip = 1'b1;
      end else begin
        res_d.val  = 32'(q);
        res_d.clip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[verif/tb_complex_alu_polar_rect_top.sv]
// Self-checking testbench for complex_alu_polar_rect_top: directed table plus
// random operand pairs, checked against an in-bench bit-exact predictor.
// Depends on capr_pkg (command codes, CORDIC constants) and the block's RTL.
module tb_complex_alu_polar_rect_top;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  // Angles in Q16.16: pi and pi/2.
  localparam int ANG_PI   = 205887;
  localparam int ANG_HALF = 102944;
  localparam int STAGES   = 16;
  localparam int DRAIN_CYCLES = STAGES + 44 + 20;
  localparam int RANDOM_ITEMS = 1600;
  localparam longint QUOT_CAP = 64'h100_0000_0000;

  typedef struct {
    logic [2:0]         cmd;
    logic               a_pol;
    logic signed [31:0] a_first;
    logic signed [31:0] a_second;
    logic               b_pol;
    logic signed [31:0] b_first;
    logic signed [31:0] b_second;
  } op_req_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
    logic               sat;
  } cplx_res_t;

  typedef struct {
    op_req_t   req;
    bit        has_exp;
    cplx_res_t exp;
  } vec_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         cmd_i;
  logic               a_is_polar_i;
  logic signed [31:0] a_first_i;
  logic signed [31:0] a_second_i;
  logic               b_is_polar_i;
  logic signed [31:0] b_first_i;
  logic signed [31:0] b_second_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] res_real_o;
  logic signed [31:0] res_imag_o;
  logic               div_zero_o;
  logic               saturated_o;

  complex_alu_polar_rect_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .a_is_polar_i (a_is_polar_i),
    .a_first_i    (a_first_i),
    .a_second_i   (a_second_i),
    .b_is_polar_i (b_is_polar_i),
    .b_first_i    (b_first_i),
    .b_second_i   (b_second_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_real_o   (res_real_o),
    .res_imag_o   (res_imag_o),
    .div_zero_o   (div_zero_o),
    .saturated_o  (saturated_o)
  );

  // Expected results in order of acceptance; the block never reorders.
  cplx_res_t pending_results[$];
  vec_row_t  vec_table[$];
  int        mismatch_count;
  int        idle_pct;
  int        stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clip to the 32-bit range, raising the clip flag when anything is lost.
  function automatic longint clip_word(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Turns one operand into rectangular parts. A polar operand goes through a
  // rotation-mode CORDIC on a Q30 angle, then is scaled by its magnitude.
  function automatic void operand_rect(logic pol, logic signed [31:0] first,
                                       logic signed [31:0] second,
                                       output longint re, output longint im,
                                       ref bit clip);
    longint f, z, x, y, nx;
    bit     flip;
    f = first;
    if (!pol) begin
      re = f;
      im = second;
      return;
    end
    z = longint'(second) * 16384;
    if (z > longint'(capr_pkg::PI30)) z = capr_pkg::PI30;
    if (z < -longint'(capr_pkg::PI30)) z = -longint'(capr_pkg::PI30);
    flip = 1'b0;
    // Fold the angle into the right half plane; cos and sin flip sign.
    if (z > longint'(capr_pkg::HALF_PI30)) begin
      z = z - longint'(capr_pkg::PI30);
      flip = 1'b1;
    end else if (z < -longint'(capr_pkg::HALF_PI30)) begin
      z = z + longint'(capr_pkg::PI30);
      flip = 1'b1;
    end
    x = capr_pkg::K30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(capr_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(capr_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    re = clip_word((f * x + (64'sd1 <<< 29)) >>> 30, clip);
    im = clip_word((f * y + (64'sd1 <<< 29)) >>> 30, clip);
  endfunction

  function automatic longint fix_mul(longint p, longint q);
    return (p * q + 64'sd32768) >>> 16;
  endfunction

  // Restoring division of (mag << 16) by den; the running quotient is capped.
  function automatic longint quot_part(logic signed [64:0] num, bit [63:0] den,
                                       ref bit clip);
    bit [127:0] dividend;
    bit [63:0]  rem, quot;
    bit         neg;
    neg = num < 0;
    dividend = {64'd0, 64'(neg ? -num : num)} << 16;
    rem = 0;
    quot = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[62:0], dividend[i]};
      quot = quot << 1;
      if (rem >= den) begin
        rem = rem - den;
        quot[0] = 1'b1;
      end
      if (quot > QUOT_CAP) quot = QUOT_CAP;
    end
    if (neg) begin
      if (quot > 64'd2147483648) begin
        clip = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(quot);
    end
    if (quot > 64'd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(quot);
  endfunction

  function automatic cplx_res_t complex_alu_result(op_req_t rq);
    longint    ar, ai, br, bi, rr, ri;
    bit        fa, fb, fr, dz;
    bit [63:0] den;
    cplx_res_t res;
    fa = 0; fb = 0; fr = 0; dz = 0;
    rr = 0; ri = 0;
    operand_rect(rq.a_pol, rq.a_first, rq.a_second, ar, ai, fa);
    operand_rect(rq.b_pol, rq.b_first, rq.b_second, br, bi, fb);
    case (rq.cmd)
      capr_pkg::CMD_ADD: begin
        rr = ar + br; ri = ai + bi; fr = fa | fb;
      end
      capr_pkg::CMD_SUB: begin
        rr = ar - br; ri = ai - bi; fr = fa | fb;
      end
      capr_pkg::CMD_MUL: begin
        // Each partial product is rounded before the sum.
        rr = fix_mul(ar, br) - fix_mul(ai, bi);
        ri = fix_mul(ar, bi) + fix_mul(ai, br);
        fr = fa | fb;
      end
      capr_pkg::CMD_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          dz = 1'b1;
        end else begin
          fr = fa | fb;
          rr = quot_part(65'(ar * br) + 65'(ai * bi), den, fr);
          ri = quot_part(65'(ai * br) - 65'(ar * bi), den, fr);
        end
      end
      capr_pkg::CMD_NEG: begin
        rr = -ar; ri = -ai; fr = fa;
      end
      default: ;
    endcase
    rr = clip_word(rr, fr);
    ri = clip_word(ri, fr);
    if (dz) fr = 1'b0;
    res.re = rr[31:0];
    res.im = ri[31:0];
    res.dz = dz;
    res.sat = fr;
    return res;
  endfunction

  function automatic op_req_t mk_req(capr_pkg::cmd_e c, logic ap, int af, int as_,
                                     logic bp, int bf, int bs);
    op_req_t r;
    r.cmd = c; r.a_pol = ap; r.a_first = af; r.a_second = as_;
    r.b_pol = bp; r.b_first = bf; r.b_second = bs;
    return r;
  endfunction

  task automatic add_row(op_req_t rq, bit has_exp = 0, int re = 0, int im = 0,
                         bit dz = 0, bit sat = 0);
    vec_row_t row;
    row.req = rq;
    row.has_exp = has_exp;
    row.exp.re = re; row.exp.im = im; row.exp.dz = dz; row.exp.sat = sat;
    vec_table.push_back(row);
  endtask

  // A value either over the full word or within +-range.
  function automatic int pick_word(int range, int full_pct);
    if ($urandom_range(99) < full_pct) return $urandom;
    return $urandom_range(2 * range) - range;
  endfunction

  function automatic op_req_t random_req();
    op_req_t r;
    r.cmd = ($urandom_range(99) < 95) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
    r.a_pol = 1'($urandom_range(1));
    r.b_pol = 1'($urandom_range(1));
    if (r.a_pol) begin
      r.a_first = pick_word(1 << 24, 20);
      r.a_second = pick_word(ANG_PI, 15);
    end else begin
      r.a_first = pick_word(1 << 22, 25);
      r.a_second = pick_word(1 << 22, 25);
    end
    if (r.b_pol) begin
      r.b_first = ($urandom_range(99) < 4) ? 0 : pick_word(1 << 24, 20);
      r.b_second = pick_word(ANG_PI, 15);
    end else if ($urandom_range(99) < 5) begin
      // A zero divisor is rare by chance, so it is forced now and then.
      r.b_first = 0;
      r.b_second = 0;
    end else begin
      r.b_first = pick_word(1 << 22, 25);
      r.b_second = pick_word(1 << 22, 25);
    end
    return r;
  endfunction

  // Presents one transaction and holds it until the block accepts it. The
  // expectation is queued at the accepting edge, before any result for it can
  // appear at the output.
  task automatic send_op(op_req_t rq, bit has_exp, cplx_res_t exp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= rq.cmd;
    a_is_polar_i <= rq.a_pol;
    a_first_i    <= rq.a_first;
    a_second_i   <= rq.a_second;
    b_is_polar_i <= rq.b_pol;
    b_first_i    <= rq.b_first;
    b_second_i   <= rq.b_second;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(has_exp ? exp : complex_alu_result(rq));
  endtask

  // The receiver stalls at random with the current stall percentage.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    cplx_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with no transaction pending: re=%0d im=%0d",
                   res_real_o, res_imag_o);
      end else begin
        want = pending_results.pop_front();
        if (res_real_o !== want.re || res_imag_o !== want.im ||
            div_zero_o !== want.dz || saturated_o !== want.sat) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: got re=%0d im=%0d dz=%b sat=%b, ",
                      "expected re=%0d im=%0d dz=%b sat=%b"},
                     res_real_o, res_imag_o, div_zero_o, saturated_o,
                     want.re, want.im, want.dz, want.sat);
        end
      end
    end
  end

  initial begin
    op_req_t rq;
    cplx_res_t none;
    none = '{default: 0};
    mismatch_count = 0;
    idle_pct = 16;
    stall_pct = 58;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cmd_i = '0;
    a_is_polar_i = 1'b0;
    a_first_i = '0;
    a_second_i = '0;
    b_is_polar_i = 1'b0;
    b_first_i = '0;
    b_second_i = '0;

    // Directed table. Rows with a typed-in result can be read off directly;
    // the rest go through the predictor.
    add_row(mk_req(capr_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
    add_row(mk_req(capr_pkg::CMD_ADD, 0, Q_MAX, Q_MAX, 0, Q_MAX, Q_MAX),
            1, Q_MAX, Q_MAX, 0, 1);
    add_row(mk_req(capr_pkg::CMD_SUB, 0, Q_MIN, Q_MIN, 0, 1, 1), 1, Q_MIN, Q_MIN, 0, 1);
    add_row(mk_req(capr_pkg::CMD_NEG, 0, Q_MIN, Q_MIN, 0, 5, 5), 1, Q_MAX, Q_MAX, 0, 1);
    add_row(mk_req(capr_pkg::CMD_DIV, 0, 12345, -999, 0, 0, 0), 1, 0, 0, 1, 0);
    add_row(mk_req(capr_pkg::CMD_DIV, 0, Q_MAX, Q_MIN, 1, 0, ANG_HALF), 1, 0, 0, 1, 0);
    add_row(mk_req(capr_pkg::cmd_e'(3'd5), 0, Q_MAX, Q_MAX, 0, Q_MAX, Q_MAX),
            1, 0, 0, 0, 0);
    add_row(mk_req(capr_pkg::cmd_e'(3'd7), 1, Q_MIN, ANG_PI, 1, Q_MAX, Q_MIN),
            1, 0, 0, 0, 0);
    // Polar conversion at the angle extremes, clamped angles, a negative
    // magnitude and full-scale magnitudes.
    add_row(mk_req(capr_pkg::CMD_ADD, 1, 65536, 0, 1, 65536, ANG_PI));
    add_row(mk_req(capr_pkg::CMD_ADD, 1, 65536, -ANG_PI, 1, 65536, ANG_HALF));
    add_row(mk_req(capr_pkg::CMD_SUB, 1, 65536, Q_MAX, 1, 65536, Q_MIN));
    add_row(mk_req(capr_pkg::CMD_ADD, 1, -65536, ANG_HALF, 0, 0, 0));
    add_row(mk_req(capr_pkg::CMD_NEG, 1, Q_MAX, ANG_HALF / 2, 1, Q_MIN, 7));
    add_row(mk_req(capr_pkg::CMD_ADD, 1, Q_MIN, -ANG_HALF, 1, Q_MAX, ANG_PI - 1));
    // Products and quotients, including saturating ones.
    add_row(mk_req(capr_pkg::CMD_MUL, 0, 3 << 16, -(2 << 16), 0, -(1 << 15), 5 << 16));
    add_row(mk_req(capr_pkg::CMD_MUL, 0, Q_MAX, Q_MIN, 0, Q_MAX, Q_MAX));
    add_row(mk_req(capr_pkg::CMD_MUL, 1, 2 << 16, ANG_HALF, 1, 3 << 16, -ANG_HALF));
    add_row(mk_req(capr_pkg::CMD_DIV, 0, 7 << 16, 3 << 16, 0, 2 << 16, -(1 << 16)));
    add_row(mk_req(capr_pkg::CMD_DIV, 0, Q_MAX, Q_MIN, 0, 1, 0));
    add_row(mk_req(capr_pkg::CMD_DIV, 0, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN));
    add_row(mk_req(capr_pkg::CMD_DIV, 0, -5, 3, 0, 0, 1));
    add_row(mk_req(capr_pkg::CMD_DIV, 1, 1 << 16, 1000, 1, 1 << 14, -ANG_PI));
    add_row(mk_req(capr_pkg::CMD_SUB, 0, Q_MAX, -1, 0, -1, Q_MAX));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vec_table[i])
      send_op(vec_table[i].req, vec_table[i].has_exp, vec_table[i].exp);

    // Random transactions in three idling phases: a slow receiver, then a
    // slow sender, then both at full rate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        idle_pct = 58;
        stall_pct = 16;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      rq = random_req();
      send_op(rq, 0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** complex_alu_polar_rect_top: PASSED **");
    end else begin
      $display("** complex_alu_polar_rect_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("ERROR: timeout with %0d results outstanding", pending_results.size());
    $display("** complex_alu_polar_rect_top: FAILED **");
    $finish;
  end

endmodule
